// File: hw/rtl/aso_pkg.sv
// ----------------------------------------------------------------------------
// aso_pkg
// Shared widths and constants for the arc scroll offset block.
// ----------------------------------------------------------------------------
package aso_pkg;

    localparam int RAD_W  = 31;
    localparam int ROOT_W = 16;
    localparam int MAG_W  = 17;

    localparam logic [15:0]      MAX_RADIUS   = 16'd46340;
    localparam logic [7:0]       ALPHA_BASE   = 8'd250;
    localparam logic [RAD_W-1:0] ROOT_TOP_BIT = RAD_W'(32'h4000_0000);

    typedef logic [RAD_W-1:0]  radicand_t;
    typedef logic [ROOT_W-1:0] root_t;

endpackage

// File: hw/rtl/aso_isqrt.sv
// ----------------------------------------------------------------------------
// aso_isqrt
// Bit-by-bit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module aso_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  aso_pkg::radicand_t radicand,
    output logic              busy,
    output aso_pkg::root_t    root
);
    import aso_pkg::*;

    logic             busy_reg, busy_next;
    logic [RAD_W-1:0] rem_reg, rem_next;
    logic [RAD_W-1:0] acc_reg, acc_next;
    logic [RAD_W-1:0] bit_reg, bit_next;
    logic [RAD_W:0]   trial;

    assign trial = {1'b0, acc_reg} + {1'b0, bit_reg};

    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = radicand;
            acc_next  = '0;
            bit_next  = ROOT_TOP_BIT;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[RAD_W-1:0];
                acc_next = (acc_reg >> 1) + bit_reg;
            end
            else
            begin
                acc_next = acc_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = acc_reg[ROOT_W-1:0];

endmodule

// File: hw/rtl/arc_scroll_offset.sv
// ----------------------------------------------------------------------------
// arc_scroll_offset
// Projects a list item's vertical distance onto a circular arc.
// ----------------------------------------------------------------------------
// Usage:
//   Write the radius through cfg_we/cfg_wdata while the block is idle.
//   Input channel in_valid/in_ready carries distance_y; one transfer gives
//   one result transfer on out_valid/out_ready with ok, shift_x and alpha.
//   A radius of zero or above 46340 gives ok=0 and zero fields.
// Sequence:
//   When the root is needed, an item goes from input to result through a
//   multiply of the radius and then of |y| on the shared 17x17 multiplier, a
//   load step and the bit-serial square root, then the output write.
//   Invalid radius or |y| >= r skips the root. One item at a time; in_ready
//   is high only while the sequencer is idle.
//   The next item is taken the cycle after the output write, so a new item
//   is accepted only once the last result has been written.
// Reset:
//   Clears the radius to zero and drops all valid flags.
// Stall:
//   A pending result waits in the output register; the sequencer holds its
//   finished result until the output register is free.
// ----------------------------------------------------------------------------
module arc_scroll_offset (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [15:0] distance_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic signed [15:0] shift_x,
    output logic [7:0]  alpha
);
    import aso_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQR  = 3'd1;
    localparam logic [2:0] S_SQY  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [15:0]      radius_reg;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [RAD_W-1:0] prod_reg, rsq_reg;
    logic             use_root_reg, use_root_next;
    logic             out_valid_reg;
    logic             ok_reg;
    logic [15:0]      shift_x_reg;
    logic [7:0]       alpha_reg;

    logic [MAG_W-1:0]   mul_a;
    logic [2*MAG_W-1:0] mul_p;
    logic               rad_ok;
    logic               near;
    logic               sqrt_start;
    logic               sqrt_busy;
    root_t              sqrt_root;
    logic               out_free;
    logic               out_write;
    logic [15:0]        shift_val;

    assign rad_ok   = (radius_reg != 16'd0) && (radius_reg <= MAX_RADIUS);
    assign near     = mag_reg >= {1'b0, radius_reg};
    assign mul_a    = (state_reg == S_SQR) ? {1'b0, radius_reg} : mag_reg;
    assign mul_p    = mul_a * mul_a;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign mag_next = distance_y[15] ? (MAG_W'(17'h10000) - {1'b0, distance_y})
                                     : {1'b0, distance_y};

    aso_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (rsq_reg - prod_reg),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    always_comb
    begin
        state_next    = state_reg;
        use_root_next = use_root_reg;
        sqrt_start    = 1'b0;
        out_write     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SQR;
            end
            S_SQR:  state_next = S_SQY;
            S_SQY:  state_next = S_LOAD;
            S_LOAD:
            begin
                use_root_next = rad_ok && !near;
                sqrt_start    = rad_ok && !near;
                state_next    = (rad_ok && !near) ? S_ROOT : S_DONE;
            end
            S_ROOT:
            begin
                if (!sqrt_busy)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign shift_val = use_root_reg ? (sqrt_root - radius_reg) : (16'd0 - radius_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                radius_reg <= cfg_wdata;
            if (out_write)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            mag_reg <= mag_next;
        if (state_reg == S_SQR || state_reg == S_SQY)
            prod_reg <= mul_p[RAD_W-1:0];
        if (state_reg == S_SQY)
            rsq_reg <= prod_reg;
        use_root_reg <= use_root_next;
        if (out_write)
        begin
            ok_reg      <= rad_ok;
            shift_x_reg <= rad_ok ? shift_val : 16'd0;
            alpha_reg   <= rad_ok ? (ALPHA_BASE + {shift_val[6:0], 1'b0}) : 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign shift_x   = shift_x_reg;
    assign alpha     = alpha_reg;

endmodule

// File: test/arc_scroll_offset_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_scroll_offset_tb
// Self-checking bench for the arc scroll offset block. A short table walks
// radius and distance extremes, invalid radii and the most negative distance.
// Random distances follow under several radii, with random stalls on both
// channels. Each result is checked against a table entry or in-bench projection.
// ----------------------------------------------------------------------------
module arc_scroll_offset_tb;

    import aso_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [15:0] shift;
        logic [7:0]  alpha;
    } proj_t;

    typedef struct packed {
        bit                 wr;
        logic [15:0]        rad;
        logic signed [15:0] dy;
        bit                 known;
        proj_t              res;
    } row_t;

    localparam int N_DIR   = 19;
    localparam int N_SEG   = 9;
    localparam int SEG_LEN = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] distance_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic ok;
    logic signed [15:0] shift_x;
    logic [7:0] alpha;

    proj_t pending_proj[$];
    logic [15:0] radius_mirror = '0;
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;

    row_t dir_tab [N_DIR] = '{
        '{1'b0, 16'd0,     16'sd0,      1'b1, '{1'b0, 16'h0000, 8'd0}},
        '{1'b0, 16'd0,     -16'sd32768, 1'b1, '{1'b0, 16'h0000, 8'd0}},
        '{1'b1, 16'd46341, 16'sd100,    1'b1, '{1'b0, 16'h0000, 8'd0}},
        '{1'b1, 16'd65535, 16'sd32767,  1'b1, '{1'b0, 16'h0000, 8'd0}},
        '{1'b1, 16'd46340, 16'sd0,      1'b1, '{1'b1, 16'h0000, 8'd250}},
        '{1'b0, 16'd46340, -16'sd32768, 1'b0, '0},
        '{1'b0, 16'd46340, 16'sd32767,  1'b0, '0},
        '{1'b0, 16'd46340, 16'sd1,      1'b0, '0},
        '{1'b1, 16'd1,     16'sd0,      1'b1, '{1'b1, 16'h0000, 8'd250}},
        '{1'b0, 16'd1,     16'sd1,      1'b1, '{1'b1, 16'hFFFF, 8'd248}},
        '{1'b0, 16'd1,     -16'sd1,     1'b1, '{1'b1, 16'hFFFF, 8'd248}},
        '{1'b0, 16'd1,     -16'sd32768, 1'b1, '{1'b1, 16'hFFFF, 8'd248}},
        '{1'b1, 16'd100,   16'sd100,    1'b1, '{1'b1, 16'hFF9C, 8'd50}},
        '{1'b0, 16'd100,   -16'sd100,   1'b1, '{1'b1, 16'hFF9C, 8'd50}},
        '{1'b0, 16'd100,   16'sd99,     1'b0, '0},
        '{1'b0, 16'd100,   16'sd60,     1'b0, '0},
        '{1'b0, 16'd100,   16'sd32767,  1'b1, '{1'b1, 16'hFF9C, 8'd50}},
        '{1'b1, 16'd40000, -16'sd32768, 1'b0, '0},
        '{1'b1, 16'd32768, -16'sd32768, 1'b0, '0}
    };

    arc_scroll_offset dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .distance_y (distance_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .shift_x    (shift_x),
        .alpha      (alpha)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // floor square root, one result bit per step from the top
    function automatic logic [15:0] floor_root(logic [31:0] v);
        logic [15:0] root;
        logic [15:0] trial;
        root = '0;
        for (int i = 15; i >= 0; i--)
        begin
            trial = root | (16'd1 << i);
            if ({16'd0, trial} * {16'd0, trial} <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic proj_t project_on_arc(logic [15:0] rad, logic signed [15:0] dy);
        proj_t p;
        longint r;
        longint mag;
        longint sh;
        p = '0;
        r = rad;
        if (rad == 16'd0 || rad > MAX_RADIUS)
            return p;
        mag = (dy < 0) ? -longint'(dy) : longint'(dy);
        if (mag >= r)
            sh = -r;
        else
            sh = -(r - longint'(floor_root(32'(r * r - mag * mag))));
        p.ok    = 1'b1;
        p.shift = sh[15:0];
        p.alpha = 8'(longint'(ALPHA_BASE) + 2 * sh);
        return p;
    endfunction

    task automatic send_distance(logic signed [15:0] dy, bit known, proj_t res);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        distance_y <= dy;
        do
            @(posedge clk);
        while (!in_ready);
        pending_proj.push_back(known ? res : project_on_arc(radius_mirror, dy));
    endtask

    task automatic drain_and_write(logic [15:0] rad);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_proj.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rad;
        @(posedge clk);
        cfg_we    <= 1'b0;
        radius_mirror = rad;
    endtask

    function automatic logic signed [15:0] pick_distance(logic [15:0] rad);
        int lim;
        int mag;
        if (rad != 16'd0 && rad <= MAX_RADIUS && $urandom_range(0, 3) != 0)
        begin
            lim = (int'(rad) - 1 > 32768) ? 32768 : int'(rad) - 1;
            mag = $urandom_range(0, lim);
            if (mag == 32768)
                return -16'sd32768;
            return $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
        end
        return 16'($urandom);
    endfunction

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_proj.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transfer: ok=%0b shift_x=%h alpha=%0d",
                             ok, shift_x, alpha);
            end
            else if (ok !== pending_proj[0].ok || shift_x !== pending_proj[0].shift
                     || alpha !== pending_proj[0].alpha)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp ok=%0b shift_x=%h alpha=%0d,",
                             pending_proj[0].ok, pending_proj[0].shift,
                             pending_proj[0].alpha,
                             " got ok=%0b shift_x=%h alpha=%0d",
                             ok, shift_x, alpha);
                void'(pending_proj.pop_front());
            end
            else
                void'(pending_proj.pop_front());
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [15:0] seg_rad [N_SEG];

        seg_rad = '{16'd46340, 16'($urandom_range(2, 46339)), 16'd0,
                    16'($urandom_range(1, 255)), 16'd46340,
                    16'($urandom_range(46341, 65535)),
                    16'($urandom_range(1000, 46340)), 16'd1,
                    16'($urandom_range(2, 46340))};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 23;
        recv_idle = 64;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].wr)
                drain_and_write(dir_tab[i].rad);
            send_distance(dir_tab[i].dy, dir_tab[i].known, dir_tab[i].res);
        end

        for (int s = 0; s < N_SEG; s++)
        begin
            send_idle = (s < 3) ? 23 : (s < 6) ? 64 : 0;
            recv_idle = (s < 3) ? 64 : (s < 6) ? 23 : 0;
            drain_and_write(seg_rad[s]);
            for (int k = 0; k < SEG_LEN; k++)
                send_distance(pick_distance(radius_mirror), 1'b0, '0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_proj.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
